// ----- hdl/bdch_pkg.sv -----
// Shared types, constants and register codes for the button debouncer.
// No dependencies; imported by every module of the block.
`default_nettype none

package bdch_pkg;

  // Phase codes of the debounce machine
  localparam logic [1:0] PH_RELEASED      = 2'd0;
  localparam logic [1:0] PH_PRESS_GRACE   = 2'd1;
  localparam logic [1:0] PH_PRESSED       = 2'd2;
  localparam logic [1:0] PH_RELEASE_GRACE = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] CFG_USE_ANALOG     = 3'd0;
  localparam logic [2:0] CFG_GRACE_MS       = 3'd1;
  localparam logic [2:0] CFG_HOLD_MS        = 3'd2;
  localparam logic [2:0] CFG_ENABLE_CLICK   = 3'd3;
  localparam logic [2:0] CFG_ENABLE_HOLD    = 3'd4;
  localparam logic [2:0] CFG_ENABLE_PRESS   = 3'd5;
  localparam logic [2:0] CFG_ENABLE_RELEASE = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [9:0]  ANALOG_THRESHOLD = 10'd511;
  localparam logic [15:0] RESET_GRACE_MS   = 16'd75;
  localparam logic [15:0] RESET_HOLD_MS    = 16'd1000;

  typedef struct packed {
    logic [9:0]  sample;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic       press_event;
    logic       click_event;
    logic       hold_event;
    logic       release_event;
    logic       bounce_seen;
    logic [1:0] button_state;
  } out_t;

  typedef struct packed {
    logic        use_analog;
    logic [15:0] grace_ms;
    logic [15:0] hold_ms;
    logic        enable_click;
    logic        enable_hold;
    logic        enable_press_event;
    logic        enable_release_event;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [31:0] grace_start;
    logic [31:0] press_start;
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/bdch_cfg.sv -----
// Configuration register file of the button debouncer.
// Depends on bdch_pkg (cfg_t, register indexes, reset values).
`default_nettype none

module bdch_cfg
  import bdch_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.use_analog           <= 1'b0;
      cfg.grace_ms             <= RESET_GRACE_MS;
      cfg.hold_ms              <= RESET_HOLD_MS;
      cfg.enable_click         <= 1'b0;
      cfg.enable_hold          <= 1'b0;
      cfg.enable_press_event   <= 1'b0;
      cfg.enable_release_event <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_USE_ANALOG:     cfg.use_analog           <= cfg_data[0];
        CFG_GRACE_MS:       cfg.grace_ms             <= cfg_data;
        CFG_HOLD_MS:        cfg.hold_ms              <= cfg_data;
        CFG_ENABLE_CLICK:   cfg.enable_click         <= cfg_data[0];
        CFG_ENABLE_HOLD:    cfg.enable_hold          <= cfg_data[0];
        CFG_ENABLE_PRESS:   cfg.enable_press_event   <= cfg_data[0];
        CFG_ENABLE_RELEASE: cfg.enable_release_event <= cfg_data[0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bdch_step.sv -----
// Next-state and event logic of the debounce machine for one sample.
// Depends on bdch_pkg (in_t, out_t, cfg_t, state_t, phase codes).
`default_nettype none

module bdch_step
  import bdch_pkg::*;
(
  input  wire cfg_t   cfg,
  input  wire state_t cur,
  input  wire in_t    item,
  output state_t      nxt,
  output out_t        res
);

  logic        level;
  logic [31:0] grace_elapsed;
  logic [31:0] held;
  logic        grace_done;
  logic        long_press;

  always_comb begin
    level         = cfg.use_analog ? (item.sample > ANALOG_THRESHOLD) : item.sample[0];
    // wrap-around differences, modulo 2^32
    grace_elapsed = item.now_ms - cur.grace_start;
    held          = item.now_ms - cur.press_start;
    grace_done    = grace_elapsed >= {16'd0, cfg.grace_ms};
    long_press    = held >= {16'd0, cfg.hold_ms};

    nxt = cur;
    res = '0;

    unique case (cur.phase)
      PH_RELEASED: begin
        if (level) begin
          nxt.phase       = PH_PRESS_GRACE;
          nxt.grace_start = item.now_ms;
        end
      end
      PH_PRESS_GRACE: begin
        if (!level) begin
          res.bounce_seen = 1'b1;
        end else if (grace_done) begin
          nxt.phase       = PH_PRESSED;
          nxt.press_start = item.now_ms;
          res.press_event = cfg.enable_press_event;
        end
      end
      PH_PRESSED: begin
        if (!level) begin
          nxt.phase       = PH_RELEASE_GRACE;
          nxt.grace_start = item.now_ms;
        end
      end
      PH_RELEASE_GRACE: begin
        if (level) begin
          res.bounce_seen = 1'b1;
        end else if (grace_done) begin
          nxt.phase         = PH_RELEASED;
          res.hold_event    = long_press & cfg.enable_hold;
          res.click_event   = cfg.enable_click & ~(long_press & cfg.enable_hold);
          res.release_event = cfg.enable_release_event;
        end
      end
    endcase

    res.button_state = nxt.phase;
  end

endmodule

`default_nettype wire

// ----- hdl/button_debounce_click_hold.sv -----
// Top level of the button debouncer with click and hold events.
// Depends on bdch_pkg, bdch_cfg and bdch_step.
//
//  channel | direction | handshake             | beat payload
//  --------+-----------+-----------------------+------------------------------------
//  in      | input     | in_valid / in_ready   | in_t : sample, now_ms
//  out     | output    | out_valid / out_ready | out_t: press/click/hold/release
//          |           |                       |        events, bounce_seen, state
//  cfg     | input     | cfg_we (no wait)      | cfg_index, cfg_data
//
// An input beat passes the input register, then the result register; one beat
// per cycle is sustained while out_ready stays high. The input register feeds
// the step logic, which updates the phase and timestamps and loads the result
// register in the same cycle. Reset (rst, synchronous) clears the pipeline
// valids, the phase and the configuration to its defaults. A stalled result
// register holds the input register too; the input side still takes a beat
// while the input register is empty.
`default_nettype none

module button_debounce_click_hold
  import bdch_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  state_t state;
  state_t state_next;
  out_t   res;

  // input register
  logic   s1_valid;
  in_t    s1_data;

  // stage advances when the result register is empty or being drained
  logic   advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  bdch_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bdch_step u_step (
    .cfg  (cfg),
    .cur  (state),
    .item (s1_data),
    .nxt  (state_next),
    .res  (res)
  );

  // control: pipeline valids and machine state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      state.phase       <= PH_RELEASED;
      state.grace_start <= '0;
      state.press_start <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
      // state moves exactly once per beat, as the beat leaves the input register
      if (s1_valid && advance) begin
        state <= state_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
    if (s1_valid && advance) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bdch_checker.sv -----
// Port-level checker for the button debouncer, bound to the top level.
// Depends on bdch_pkg (phase codes, out_t) and button_debounce_click_hold.
`default_nettype none

module bdch_checker
  import bdch_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  // a result beat held back by the sink keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // a press event only comes with the pressed phase
  a_press_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.press_event |-> out_data.button_state == PH_PRESSED)
    else $error("press event outside pressed phase");

  // release-side events only on return to released, never click and hold together
  a_release_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.click_event || out_data.hold_event || out_data.release_event)
    |-> out_data.button_state == PH_RELEASED
        && !(out_data.click_event && out_data.hold_event))
    else $error("bad release event combination");

  // a bounce keeps the machine in a grace phase
  a_bounce_grace: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bounce_seen
    |-> out_data.button_state == PH_PRESS_GRACE
        || out_data.button_state == PH_RELEASE_GRACE)
    else $error("bounce flagged outside a grace phase");

endmodule

bind button_debounce_click_hold bdch_checker u_bdch_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
